@@ sv/phd_pkg.sv @@
`default_nettype none

package phd_pkg;

    localparam int PIX_W       = 8;
    localparam int VSUM_W      = 12;
    localparam int HSUM_W      = 15;
    localparam int PROD_W      = 30;
    localparam int DIV_MUL     = 20972;
    localparam int DIV_SHIFT   = 21;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int RESET_WIDTH  = 512;
    localparam int RESET_HEIGHT = 512;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [VSUM_W-1:0] blue;
        logic [VSUM_W-1:0] green;
        logic [VSUM_W-1:0] red;
    } vsum_t;

    typedef struct packed {
        logic [HSUM_W-1:0] blue;
        logic [HSUM_W-1:0] green;
        logic [HSUM_W-1:0] red;
    } hsum_t;

    // control carried alongside a word while the row store read completes
    typedef struct packed {
        logic [1:0] slot;
        logic       first;
        logic       emit;
        logic       back2;
        logic       last;
    } s1_ctl_t;

    // 1,2,4,2,1 tap on bytes
    function automatic logic [VSUM_W-1:0] vtap(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] m,
                                               input logic [PIX_W-1:0] d,
                                               input logic [PIX_W-1:0] e);
        return VSUM_W'(a) + (VSUM_W'(b) << 1) + (VSUM_W'(m) << 2)
             + (VSUM_W'(d) << 1) + VSUM_W'(e);
    endfunction

    // 1,2,4,2,1 tap on column sums
    function automatic logic [HSUM_W-1:0] htap(input logic [VSUM_W-1:0] a,
                                               input logic [VSUM_W-1:0] b,
                                               input logic [VSUM_W-1:0] m,
                                               input logic [VSUM_W-1:0] d,
                                               input logic [VSUM_W-1:0] e);
        return HSUM_W'(a) + (HSUM_W'(b) << 1) + (HSUM_W'(m) << 2)
             + (HSUM_W'(d) << 1) + HSUM_W'(e);
    endfunction

    function automatic vsum_t vcol(input rgb_t a, input rgb_t b, input rgb_t m,
                                   input rgb_t d, input rgb_t e);
        vsum_t v;
        v.red   = vtap(a.red,   b.red,   m.red,   d.red,   e.red);
        v.green = vtap(a.green, b.green, m.green, d.green, e.green);
        v.blue  = vtap(a.blue,  b.blue,  m.blue,  d.blue,  e.blue);
        return v;
    endfunction

    function automatic hsum_t hrow(input vsum_t a, input vsum_t b, input vsum_t m,
                                   input vsum_t d, input vsum_t e);
        hsum_t h;
        h.red   = htap(a.red,   b.red,   m.red,   d.red,   e.red);
        h.green = htap(a.green, b.green, m.green, d.green, e.green);
        h.blue  = htap(a.blue,  b.blue,  m.blue,  d.blue,  e.blue);
        return h;
    endfunction

    // exact floor(x/100) for x < 25600 by reciprocal multiply
    function automatic logic [PIX_W-1:0] div100(input logic [HSUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(DIV_MUL);
        return p[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
    endfunction

endpackage

`default_nettype wire

@@ sv/pyramid_halve_downsampler.sv @@
`default_nettype none

// Path: an accepted word passes the row store read stage, the sum stage and the output
// register before its result, if any, shows on m_tvalid. Throughput: one pixel per cycle;
// stalls only when the output register, the sum stage and the row store read stage are full.
// Reset: asynchronous, active low; clears counters, column window, valids and sets
// width/height to 512. The row store is not cleared and needs no clearing pass.
module pyramid_halve_downsampler
    import phd_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [23:0]           m_tdata,   // red_out, green_out, blue_out
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;
    localparam int RW = IMG_H_W + 1;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [AW-1:0]      col_reg;
    logic [IMG_H_W-1:0] row_reg;

    logic [WW-1:0]      width_ext;
    logic [WW-1:0]      eff_w;
    logic [RW-1:0]      h_lim;
    logic               col_wrap;
    logic [RW-1:0]      row_a;
    logic [RW-1:0]      row_b;
    logic [RW-1:0]      row_c;
    logic [IMG_H_W-1:0] row_cur;
    logic [AW-1:0]      col_cur;
    logic               last_col;
    logic               row_ok;
    logic               emit_a;
    logic               emit_b;
    logic [AW-1:0]      col_next;
    logic [IMG_H_W-1:0] row_next;
    s1_ctl_t            ctl0;

    logic               accept;
    logic               s1_ready;
    logic               s1_go;
    logic               s2_ready;
    logic               s2_go;
    logic               out_ready;

    logic               v1_reg;
    s1_ctl_t            ctl1_reg;
    rgb_t               pix1_reg;
    rgb_t               ram_q [4];

    rgb_t               q_one;
    rgb_t               q_two_a;
    rgb_t               q_four;
    rgb_t               q_two_b;
    vsum_t              cur;
    vsum_t              win_reg [4];
    vsum_t              win_use [4];
    hsum_t              hsum;

    logic               v2_reg;
    hsum_t              sum2_reg;
    logic               last2_reg;

    logic               m_valid_reg;
    rgb_t               m_data_reg;
    logic               m_last_reg;
    rgb_t               m_data_next;

    // ---------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_W_W'(RESET_WIDTH);
            height_reg <= IMG_H_W'(RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- position counters and emit decision
    always_comb
    begin
        width_ext = WW'(width_reg);
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (width_ext > WW'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = width_ext;

        h_lim = (height_reg == '0) ? (RW'(1) << IMG_H_W) : RW'(height_reg);

        // shrunk size since the last word
        col_wrap = WW'(col_reg) >= eff_w;
        row_a    = col_wrap ? RW'(row_reg) + RW'(1) : RW'(row_reg);
        row_b    = (row_a >= h_lim) ? '0 : row_a;
        row_cur  = row_b[IMG_H_W-1:0];
        col_cur  = col_wrap ? '0 : col_reg;

        last_col = (WW'(col_cur) + WW'(1)) >= eff_w;
        row_c    = RW'(row_cur) + RW'(1);
        col_next = last_col ? '0 : col_cur + AW'(1);
        if (last_col)
            row_next = (row_c >= h_lim) ? '0 : row_c[IMG_H_W-1:0];
        else
            row_next = row_cur;

        row_ok = !row_cur[0] && (row_cur[IMG_H_W-1:2] != '0);
        emit_a = row_ok && !col_cur[0] && (col_cur[AW-1:1] != '0);
        emit_b = row_ok && !eff_w[0] && last_col;

        ctl0.slot  = row_cur[1:0];
        ctl0.first = col_cur == '0;
        ctl0.emit  = emit_a || emit_b;
        ctl0.back2 = emit_a;
        ctl0.last  = last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- handshake
    assign out_ready = !m_valid_reg || m_tready;
    assign s2_ready  = !v2_reg || out_ready;
    assign s2_go     = v2_reg && out_ready;
    assign s1_ready  = !v1_reg || s2_ready;
    assign s1_go     = v1_reg && s2_ready;
    assign accept    = s_tvalid && s1_ready;
    assign s_tready  = s1_ready;

    // ---------------- row store: one bank per row slot
    for (genvar i = 0; i < 4; i++)
    begin : g_bank
        phd_ram #(
            .WIDTH ($bits(rgb_t)),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk   (clk),
            .we    (accept && (ctl0.slot == 2'(i))),
            .waddr (col_cur),
            .wdata (s_tdata),
            .re    (accept),
            .raddr (col_cur),
            .rdata (ram_q[i])
        );
    end

    // ---------------- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (accept)
        begin
            v1_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl1_reg <= ctl0;
            pix1_reg <= s_tdata;
        end
    end

    // oldest slot weight 1, middle row weight 4
    always_comb
    begin
        case (ctl1_reg.slot)
            2'd0:
            begin
                q_one = ram_q[0]; q_two_a = ram_q[1]; q_four = ram_q[2]; q_two_b = ram_q[3];
            end
            2'd1:
            begin
                q_one = ram_q[1]; q_two_a = ram_q[2]; q_four = ram_q[3]; q_two_b = ram_q[0];
            end
            2'd2:
            begin
                q_one = ram_q[2]; q_two_a = ram_q[3]; q_four = ram_q[0]; q_two_b = ram_q[1];
            end
            default:
            begin
                q_one = ram_q[3]; q_two_a = ram_q[0]; q_four = ram_q[1]; q_two_b = ram_q[2];
            end
        endcase

        cur = vcol(q_one, q_two_a, q_four, q_two_b, pix1_reg);

        for (int i = 0; i < 4; i++)
        begin
            win_use[i] = ctl1_reg.first ? '0 : win_reg[i];
        end

        if (ctl1_reg.back2)
            hsum = hrow(win_use[3], win_use[2], win_use[1], win_use[0], cur);
        else
            hsum = hrow(win_use[2], win_use[1], win_use[0], cur, '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_go)
        begin
            win_reg[0] <= cur;
            win_reg[1] <= win_use[0];
            win_reg[2] <= win_use[1];
            win_reg[3] <= win_use[2];
        end
    end

    // ---------------- stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            v2_reg <= ctl1_reg.emit;
        end
        else if (s2_go)
        begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            sum2_reg  <= hsum;
            last2_reg <= ctl1_reg.last;
        end
    end

    // ---------------- output register
    always_comb
    begin
        m_data_next.red   = div100(sum2_reg.red);
        m_data_next.green = div100(sum2_reg.green);
        m_data_next.blue  = div100(sum2_reg.blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            m_data_reg <= m_data_next;
            m_last_reg <= last2_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

@@ sv/phd_ram.sv @@
`default_nettype none

module phd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/phd_checker.sv @@
`default_nettype none

module phd_checker
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [23:0]           m_tdata,
    input wire logic                  m_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // an empty output register means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // three register stages between input and output
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("output sooner than pipeline depth after reset");

endmodule

bind pyramid_halve_downsampler phd_checker u_phd_checker (.*);

`default_nettype wire

@@ tb/sv/pyramid_halve_check.sv @@
`timescale 1ns / 1ps

module pyramid_halve_check
    import phd_pkg::*;
#(
    parameter int MAX_W = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [23:0]           m_tdata,   // red_out, green_out, blue_out
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fails,
    output int                         pending,
    output int                         results
);

    typedef struct packed {
        logic row_end;
        rgb_t pix;
    } filtered_word_t;

    rgb_t           line_mem [4*MAX_W];
    rgb_t           col_win [4][5];
    int unsigned    width_reg;
    int unsigned    height_reg;
    int unsigned    col_pos;
    int unsigned    row_pos;
    filtered_word_t filtered_q [$];

    function automatic int unsigned tap_w(input int k);
        return (k == 2) ? 4 : ((k == 1 || k == 3) ? 2 : 1);
    endfunction

    task automatic clear_window();
        int j;
        int m;
        for (j = 0; j < 4; j++)
            for (m = 0; m < 5; m++)
                col_win[j][m] = '0;
    endtask

    task automatic clear_model();
        int i;
        for (i = 0; i < 4*MAX_W; i++)
            line_mem[i] = '0;
        clear_window();
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        col_pos    = 0;
        row_pos    = 0;
        filtered_q.delete();
    endtask

    // one pixel through the 5x5 pyramid filter; queues the filtered word if one falls due
    task automatic filter_pixel(input rgb_t px);
        int unsigned    w;
        int unsigned    h;
        int unsigned    half;
        int unsigned    c;
        int unsigned    idx;
        int unsigned    sr;
        int unsigned    sg;
        int unsigned    sb;
        int unsigned    wt;
        int             back;
        int             o;
        int             k;
        int             m;
        int             j;
        bit             emit;
        rgb_t           vec [5];
        rgb_t           src;
        filtered_word_t res;
        w    = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h    = (height_reg == 0) ? 65536 : height_reg;
        half = w / 2;
        idx  = 0;
        back = 0;
        emit = 1'b0;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        if (c == 0)
            clear_window();
        for (m = 0; m < 4; m++)
            vec[m] = line_mem[((row_pos + m) % 4) * MAX_W + c];
        vec[4] = px;
        line_mem[(row_pos % 4) * MAX_W + c] = px;
        if (row_pos % 2 == 0 && row_pos >= 4)
        begin
            if (c % 2 == 0 && c >= 2 && (c - 2) / 2 < half)
            begin
                emit = 1'b1;
                idx  = (c - 2) / 2;
                back = 2;
            end
            else if (w % 2 == 0 && c == w - 1 && half > 0)
            begin
                // right-hand column beyond the image counts as zero
                emit = 1'b1;
                idx  = half - 1;
                back = 1;
            end
            if (emit)
            begin
                sr = 0;
                sg = 0;
                sb = 0;
                for (k = 0; k < 5; k++)
                begin
                    o = back + 2 - k;
                    if (o >= 0)
                    begin
                        for (m = 0; m < 5; m++)
                        begin
                            src = (o == 0) ? vec[m] : col_win[o-1][m];
                            wt  = tap_w(k) * tap_w(m);
                            sr += wt * src.red;
                            sg += wt * src.green;
                            sb += wt * src.blue;
                        end
                    end
                end
                res.pix.red   = 8'(sr / 100);
                res.pix.green = 8'(sg / 100);
                res.pix.blue  = 8'(sb / 100);
                res.row_end   = (idx == half - 1);
                filtered_q.push_back(res);
            end
        end
        for (j = 3; j > 0; j--)
            col_win[j] = col_win[j-1];
        col_win[0] = vec;
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            fails   = 0;
            results = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx_t'(cfg_index) == CFG_WIDTH)
                    width_reg = cfg_data[IMG_W_W-1:0];
                else
                    height_reg = cfg_data[IMG_H_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                    fails++;
                end
                else
                begin
                    filtered_word_t want;
                    rgb_t           got;
                    want = filtered_q.pop_front();
                    got  = m_tdata;
                    results++;
                    if (got.red !== want.pix.red)
                        report_field("red", want.pix.red, got.red);
                    if (got.green !== want.pix.green)
                        report_field("green", want.pix.green, got.green);
                    if (got.blue !== want.pix.blue)
                        report_field("blue", want.pix.blue, got.blue);
                    if (m_tlast !== want.row_end)
                        report_field("row_end", 8'(want.row_end), 8'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                filter_pixel(rgb_t'(s_tdata));
            pending <= filtered_q.size();
        end
    end

endmodule

@@ tb/sv/pyramid_halve_downsampler_tb.sv @@
`timescale 1ns / 1ps

module pyramid_halve_downsampler_tb;
    import phd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_PIXELS  = 800;
    localparam int HOLD_CYCLES    = 300;
    localparam int WIDE           = 1024;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // red_in, green_in, blue_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // red_out, green_out, blue_out
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          fails;
    int          pending;
    int          results;
    int          stall_pct     = 0;
    int          send_idle_pct = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          pixels_sent   = 0;
    int          size_writes   = 0;
    int unsigned eff_w         = RESET_WIDTH;
    int unsigned eff_h         = RESET_HEIGHT;
    int unsigned at_col        = 0;
    int unsigned at_row        = 0;

    pyramid_halve_downsampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pyramid_halve_check filter_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .results   (results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d still expected",
                     $time, WATCHDOG_LIMIT, pending);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic rgb_t rand_pixel();
        rgb_t p;
        int   sel;
        sel = $urandom_range(0, 9);
        p   = 24'($urandom);
        if (sel >= 6 && sel < 9)
        begin
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else if (sel == 9)
            p = '1;
        return p;
    endfunction

    task automatic set_mode(input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
    endtask

    // both registers, width with junk in the unused top bits
    task automatic set_size(input int unsigned w_raw, input int unsigned h_raw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= {5'($urandom_range(0, 31)), 11'(w_raw)};
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= 16'(h_raw);
        @(posedge clk);
        cfg_we <= 1'b0;
        size_writes++;
        eff_w = (w_raw == 0) ? 1 : ((w_raw > WIDE) ? WIDE : w_raw);
        eff_h = (h_raw == 0) ? 65536 : h_raw;
        if (at_col >= eff_w)
        begin
            at_col = 0;
            at_row++;
        end
        if (at_row >= eff_h)
            at_row = 0;
    endtask

    task automatic send_pixel(input rgb_t px);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        at_col++;
        if (at_col >= eff_w)
        begin
            at_col = 0;
            at_row++;
            if (at_row >= eff_h)
                at_row = 0;
        end
    endtask

    task automatic send_count(input int n);
        repeat (n)
            send_pixel(rand_pixel());
    endtask

    // a whole frame if at its start, else the rest of the current one
    task automatic run_to_frame_end();
        do
            send_pixel(rand_pixel());
        while (at_col != 0 || at_row != 0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int          mode;
        int          phase_start;
        int unsigned w;
        int unsigned h;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame that yields output, all white; then a chequerboard at odd width
        set_size(2, 5);
        repeat (10)
            send_pixel('1);
        drain();
        set_size(3, 5);
        repeat (15)
            send_pixel(((at_col + at_row) % 2 == 1) ? '1 : '0);
        drain();

        // odd sizes: zero and unit width, short frames, unbounded and maximal height
        set_size(0, 5);
        send_count(5);
        drain();
        set_size(1, 3);
        send_count(9);
        drain();
        set_size(7, 4);
        send_count(56);
        drain();
        set_size(2, 0);
        send_count(24);
        drain();
        set_size(2, 5);
        run_to_frame_end();
        drain();
        set_size(3, 65535);
        send_count(30);
        drain();
        set_size(3, 5);
        run_to_frame_end();
        drain();

        // shrink the width, then the height, part way through a frame
        set_size(10, 9);
        send_count(66);
        drain();
        set_size(4, 9);
        run_to_frame_end();
        drain();
        set_size(8, 12);
        send_count(72);
        drain();
        set_size(8, 6);
        run_to_frame_end();
        drain();

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       set_mode(0, 0);
                1:       set_mode(82, 0);
                2:       set_mode(0, 82);
                default: set_mode(23, 23);
            endcase
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < RANDOM_PIXELS / 4)
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(2, 16);
                h = $urandom_range(5, 10);
                set_size(w, h);
                if ($urandom_range(0, 4) == 0)
                begin
                    send_count($urandom_range(1, w * h - 1));
                    drain();
                    set_size($urandom_range(2, w), $urandom_range(5, 12));
                end
                run_to_frame_end();
                drain();
            end
        end

        // width beyond the store saturates; then a long hold-off backs the block up
        set_mode(0, 0);
        set_size(2047, 5);
        send_count(40);
        drain();
        set_size(32, 5);
        run_to_frame_end();
        drain();
        hold_req <= hold_req + 1;
        run_to_frame_end();

        drain();
        $display("%0d pixels sent under %0d size settings, %0d filtered words checked",
                 pixels_sent, size_writes, results);
        $display("widths 0 to 2047, heights 0 to 65535, mid-frame shrinks, idle and stall mixes");
        if (fails == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
